### hw/rtl/bcs_pkg.sv
// Shared widths and types for the basis change solver.
// Used by bcs_div and basis_change_3x3_solver; depends on nothing.
package bcs_pkg;
    localparam int IW      = 16;   // input component, Q3.12
    localparam int CW      = 33;   // cross product component
    localparam int PRW     = 49;   // component times cross term
    localparam int PW      = 51;   // determinant or numerator
    localparam int MW      = 50;   // magnitude of PW value
    localparam int RW      = 64;   // partial remainder
    localparam int QW      = 24;   // quotient / output coordinate
    localparam int SW      = RW + QW;  // trial compare width
    localparam int FRAC    = 13;   // 12 fraction bits plus one rounding bit
    localparam int DIV_LAT = QW + 2;
    localparam int IN_W    = 12 * IW;
    localparam int OUT_W   = 3 * QW;

    typedef logic signed [IW-1:0] comp_t;
    typedef logic signed [PW-1:0] wide_t;
    typedef logic signed [QW-1:0] coord_t;
endpackage

### hw/rtl/bcs_div.sv
// Pipelined restoring divider: num * 4096 / den, round half away, saturate.
// Depends on bcs_pkg; one quotient bit per stage.
module bcs_div (
    input  logic              aclk,
    input  logic              en,
    input  bcs_pkg::wide_t    num_i,
    input  bcs_pkg::wide_t    den_i,
    output bcs_pkg::coord_t   coord_o
);
    logic [bcs_pkg::RW-1:0]  rem_reg [0:bcs_pkg::QW];
    logic [bcs_pkg::MW:0]    d_reg   [0:bcs_pkg::QW];
    logic [bcs_pkg::QW-1:0]  q_reg   [0:bcs_pkg::QW];
    logic                    neg_reg [0:bcs_pkg::QW];
    logic                    sat_reg [0:bcs_pkg::QW];
    bcs_pkg::coord_t         coord_reg;

    logic [bcs_pkg::MW-1:0]  an, ad;
    logic [bcs_pkg::RW-1:0]  rem0;
    logic [bcs_pkg::MW:0]    d0;
    logic [bcs_pkg::QW:0]    mag;

    always_comb begin
        an   = num_i[bcs_pkg::PW-1] ? bcs_pkg::MW'(-num_i) : bcs_pkg::MW'(num_i);
        ad   = den_i[bcs_pkg::PW-1] ? bcs_pkg::MW'(-den_i) : bcs_pkg::MW'(den_i);
        rem0 = (bcs_pkg::RW'(an) << bcs_pkg::FRAC) + bcs_pkg::RW'(ad);
        d0   = {ad, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0;
            d_reg[0]   <= d0;
            q_reg[0]   <= '0;
            neg_reg[0] <= num_i[bcs_pkg::PW-1] ^ den_i[bcs_pkg::PW-1];
            sat_reg[0] <= bcs_pkg::SW'(rem0) >= (bcs_pkg::SW'(d0) << bcs_pkg::QW);
        end
    end

    for (genvar k = 1; k <= bcs_pkg::QW; k++) begin : g_bit
        localparam int B = bcs_pkg::QW - k;
        logic [bcs_pkg::SW-1:0] dsh;
        logic                   take;
        assign dsh  = bcs_pkg::SW'(d_reg[k-1]) << B;
        assign take = bcs_pkg::SW'(rem_reg[k-1]) >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? bcs_pkg::RW'(bcs_pkg::SW'(rem_reg[k-1]) - dsh)
                                   : rem_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (bcs_pkg::QW'(take) << B);
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    // clamp magnitude to the signed range, then apply the sign
    always_comb begin
        if (neg_reg[bcs_pkg::QW]) begin
            mag = (sat_reg[bcs_pkg::QW] || q_reg[bcs_pkg::QW] > (1 << (bcs_pkg::QW-1)))
                ? (bcs_pkg::QW+1)'(1 << (bcs_pkg::QW-1))
                : (bcs_pkg::QW+1)'(q_reg[bcs_pkg::QW]);
        end else begin
            mag = (sat_reg[bcs_pkg::QW] || q_reg[bcs_pkg::QW] > ((1 << (bcs_pkg::QW-1)) - 1))
                ? (bcs_pkg::QW+1)'((1 << (bcs_pkg::QW-1)) - 1)
                : (bcs_pkg::QW+1)'(q_reg[bcs_pkg::QW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            coord_reg <= neg_reg[bcs_pkg::QW] ? bcs_pkg::QW'(-mag) : bcs_pkg::QW'(mag);
        end
    end

    assign coord_o = coord_reg;
endmodule

### hw/rtl/basis_change_3x3_solver.sv
// Basis change by Cramer's rule: coordinates of a vector in a 3x3 basis.
// Depends on bcs_pkg and bcs_div.
//
//   channel | dir | tdata (low bit up)                          | tuser
//   s_      | in  | vec xyz, fwd xyz, up xyz, side xyz (16b ea.) | -
//   m_      | out | coord_x, coord_y, coord_z (24b each)         | singular
//
// One request per cycle unless the output stalls; stages: input register, cross products,
// products, sums, then the 24-stage divider with entry and exit registers.
// The divider chain, one quotient bit per stage, sets the depth.
// Reset clears only the valid bits; payload registers are not reset.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module basis_change_3x3_solver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bcs_pkg::IN_W-1:0]    s_tdata,   // vec_x..z, fwd_x..z, up_x..z, side_x..z
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bcs_pkg::OUT_W-1:0]   m_tdata,   // coord_x, coord_y, coord_z
    output logic                        m_tuser    // singular
);
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage A: capture the request
    bcs_pkg::comp_t v_reg [0:2];
    bcs_pkg::comp_t f_reg [0:2];
    bcs_pkg::comp_t u_reg [0:2];
    bcs_pkg::comp_t s_reg [0:2];
    logic           va_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v_reg[i] <= s_tdata[i*bcs_pkg::IW +: bcs_pkg::IW];
                f_reg[i] <= s_tdata[(3+i)*bcs_pkg::IW +: bcs_pkg::IW];
                u_reg[i] <= s_tdata[(6+i)*bcs_pkg::IW +: bcs_pkg::IW];
                s_reg[i] <= s_tdata[(9+i)*bcs_pkg::IW +: bcs_pkg::IW];
            end
        end
    end

    // stage B: cross products u x s, s x f, f x u; carry v and f
    logic signed [bcs_pkg::CW-1:0] us_reg [0:2];
    logic signed [bcs_pkg::CW-1:0] sf_reg [0:2];
    logic signed [bcs_pkg::CW-1:0] fu_reg [0:2];
    bcs_pkg::comp_t                vb_reg [0:2];
    bcs_pkg::comp_t                fb_reg [0:2];
    logic                          vb_valid_reg;

    function automatic logic signed [bcs_pkg::CW-1:0] xterm(
        input bcs_pkg::comp_t a, input bcs_pkg::comp_t b,
        input bcs_pkg::comp_t c, input bcs_pkg::comp_t d);
        logic signed [bcs_pkg::CW-1:0] p, q;
        p = a * b;
        q = c * d;
        return p - q;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            us_reg[0] <= xterm(u_reg[1], s_reg[2], u_reg[2], s_reg[1]);
            us_reg[1] <= xterm(u_reg[2], s_reg[0], u_reg[0], s_reg[2]);
            us_reg[2] <= xterm(u_reg[0], s_reg[1], u_reg[1], s_reg[0]);
            sf_reg[0] <= xterm(s_reg[1], f_reg[2], s_reg[2], f_reg[1]);
            sf_reg[1] <= xterm(s_reg[2], f_reg[0], s_reg[0], f_reg[2]);
            sf_reg[2] <= xterm(s_reg[0], f_reg[1], s_reg[1], f_reg[0]);
            fu_reg[0] <= xterm(f_reg[1], u_reg[2], f_reg[2], u_reg[1]);
            fu_reg[1] <= xterm(f_reg[2], u_reg[0], f_reg[0], u_reg[2]);
            fu_reg[2] <= xterm(f_reg[0], u_reg[1], f_reg[1], u_reg[0]);
            vb_reg    <= v_reg;
            fb_reg    <= f_reg;
        end
    end

    // stage C: component products of the four triple products
    logic signed [bcs_pkg::PRW-1:0] pd_reg [0:2];
    logic signed [bcs_pkg::PRW-1:0] p0_reg [0:2];
    logic signed [bcs_pkg::PRW-1:0] p1_reg [0:2];
    logic signed [bcs_pkg::PRW-1:0] p2_reg [0:2];
    logic                           vc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pd_reg[i] <= fb_reg[i] * us_reg[i];
                p0_reg[i] <= vb_reg[i] * us_reg[i];
                p1_reg[i] <= vb_reg[i] * sf_reg[i];
                p2_reg[i] <= vb_reg[i] * fu_reg[i];
            end
        end
    end

    // stage D: sum into determinant and numerators
    bcs_pkg::wide_t det_reg, n0_reg, n1_reg, n2_reg;
    logic           vd_reg;

    function automatic bcs_pkg::wide_t sum3(
        input logic signed [bcs_pkg::PRW-1:0] a,
        input logic signed [bcs_pkg::PRW-1:0] b,
        input logic signed [bcs_pkg::PRW-1:0] c);
        return bcs_pkg::PW'(a) + bcs_pkg::PW'(b) + bcs_pkg::PW'(c);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= sum3(pd_reg[0], pd_reg[1], pd_reg[2]);
            n0_reg  <= sum3(p0_reg[0], p0_reg[1], p0_reg[2]);
            n1_reg  <= sum3(p1_reg[0], p1_reg[1], p1_reg[2]);
            n2_reg  <= sum3(p2_reg[0], p2_reg[1], p2_reg[2]);
        end
    end

    // singular: feed 0 / 1 so the divider yields zero coordinates
    logic           sing;
    bcs_pkg::wide_t den, num0, num1, num2;
    assign sing = det_reg == '0;
    assign den  = sing ? bcs_pkg::PW'(1) : det_reg;
    assign num0 = sing ? '0 : n0_reg;
    assign num1 = sing ? '0 : n1_reg;
    assign num2 = sing ? '0 : n2_reg;

    bcs_pkg::coord_t cx, cy, cz;
    bcs_div u_div_x (.aclk(aclk), .en(en), .num_i(num0), .den_i(den), .coord_o(cx));
    bcs_div u_div_y (.aclk(aclk), .en(en), .num_i(num1), .den_i(den), .coord_o(cy));
    bcs_div u_div_z (.aclk(aclk), .en(en), .num_i(num2), .den_i(den), .coord_o(cz));

    // valid and singular flags travel alongside the divider
    logic [bcs_pkg::DIV_LAT-1:0] vdiv_reg;
    logic [bcs_pkg::DIV_LAT-1:0] sg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg       <= 1'b0;
            vb_valid_reg <= 1'b0;
            vc_reg       <= 1'b0;
            vd_reg       <= 1'b0;
            vdiv_reg     <= '0;
        end else if (en) begin
            va_reg       <= s_tvalid;
            vb_valid_reg <= va_reg;
            vc_reg       <= vb_valid_reg;
            vd_reg       <= vc_reg;
            vdiv_reg     <= {vdiv_reg[bcs_pkg::DIV_LAT-2:0], vd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sg_reg <= {sg_reg[bcs_pkg::DIV_LAT-2:0], sing};
        end
    end

    assign m_tvalid = vdiv_reg[bcs_pkg::DIV_LAT-1];
    assign m_tuser  = sg_reg[bcs_pkg::DIV_LAT-1];
    assign m_tdata  = {cz, cy, cx};

`ifndef SYNTH
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("singular result with nonzero coordinates");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> va_reg)
        else $error("accepted request not captured");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
`endif
endmodule
